>>> rtl/core/spme_pkg.sv
// Shared constants and word types of the shortest path matrix engine.
package spme_pkg;

	// Default number of nodes in the graph
	localparam int NODE_COUNT_DEF = 16;

	// Field widths
	localparam int ID_WIDTH     = 4;
	localparam int WEIGHT_WIDTH = 20;
	localparam int DIST_WIDTH   = 24;

	// Largest number of results one run produces
	localparam int MAX_RESULTS = 16;

	// Reset value of the no-edge register
	localparam logic [WEIGHT_WIDTH-1:0] NO_EDGE_RESET = WEIGHT_WIDTH'(99999);

	// Opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RUN  = 1'b1;

	// Input word: one matrix weight write or a run request
	typedef struct packed {
		logic                    op;
		logic [ID_WIDTH-1:0]     from_node;
		logic [ID_WIDTH-1:0]     to_node;
		logic [WEIGHT_WIDTH-1:0] edge_weight;
	} in_word_t;

	// Result word: one node's distance and predecessor
	typedef struct packed {
		logic [ID_WIDTH-1:0]   node_index;
		logic [DIST_WIDTH-1:0] path_distance;
		logic [ID_WIDTH-1:0]   predecessor;
		logic                  last_result;
	} out_word_t;

endpackage

>>> rtl/core/spme_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module spme_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_q;

endmodule

>>> rtl/core/shortest_path_matrix_engine_core.sv
// Top level of the shortest path matrix engine: sequencer, datapath and memories.
//
//  channel   direction  handshake              word
//  -------   ---------  ---------------------  -----------------------------------
//  in        sink       in_valid / in_stall    load weight (op 0) or run search (op 1)
//  out       source     out_valid / out_stall  node, distance, predecessor, last
//  cfg       sink       cfg_wr_en              no_edge_value, 20 bits
//
// A load word with in-range nodes writes one weight. A run of N nodes first searches: it scans
// the distance memory once per selection and reads one weight row per relaxation, one entry
// per cycle; then the results leave one at a time, each read from the distance memory and then loaded.
// The input stalls from the run until the last result sits in the output register.
// Reset clears the control state and the visited flags; the weight memory holds
// whatever was last written. Output stalls hold the result and the sequencer.
module shortest_path_matrix_engine_core #(
	parameter int NODE_COUNT = spme_pkg::NODE_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  spme_pkg::in_word_t                  in_word,
	output logic                                out_valid,
	input  logic                                out_stall,
	output spme_pkg::out_word_t                 out_word,
	input  logic                                cfg_wr_en,
	input  logic [spme_pkg::WEIGHT_WIDTH-1:0]   cfg_wr_data
);

	localparam int NW    = $clog2(NODE_COUNT);
	localparam int CW    = $clog2(NODE_COUNT + 1);
	localparam int AW    = $clog2(NODE_COUNT * NODE_COUNT);
	localparam int WW    = spme_pkg::WEIGHT_WIDTH;
	localparam int DSW   = spme_pkg::DIST_WIDTH;
	localparam int DW    = DSW + NW;
	localparam int OUT_N = (NODE_COUNT < spme_pkg::MAX_RESULTS) ? NODE_COUNT
	                                                            : spme_pkg::MAX_RESULTS;

	// Sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_INIT   = 3'd1;
	localparam logic [2:0] ST_SEL    = 3'd2;
	localparam logic [2:0] ST_RELAX  = 3'd3;
	localparam logic [2:0] ST_OUT_RD = 3'd4;
	localparam logic [2:0] ST_OUT_LD = 3'd5;

	logic [2:0]            state_q;
	logic [CW-1:0]         cnt_q;
	logic [NW-1:0]         cnt_idx;
	logic                  v_s1;
	logic [NW-1:0]         idx_s1;
	logic [NODE_COUNT-1:0] visited_q;
	logic [DSW-1:0]        best_q;
	logic [NW-1:0]         pick_q;
	logic                  found_q;
	logic [WW-1:0]         no_edge_q;
	logic                  out_valid_q;
	spme_pkg::out_word_t   out_word_q;

	logic                  in_acc;
	logic                  wr_in_range;
	logic                  issue;
	logic                  scan_state;
	logic                  scan_done;
	logic                  out_free;
	logic                  last_k;

	logic                  w_we;
	logic [AW-1:0]         w_waddr;
	logic [AW-1:0]         w_raddr;
	logic [WW-1:0]         w_rdata;

	logic                  d_we;
	logic [DW-1:0]         d_wdata;
	logic [DW-1:0]         d_rdata;
	logic [DSW-1:0]        d_dist;
	logic [NW-1:0]         d_pred;

	logic [DSW:0]          sum;
	logic [DSW-1:0]        cand;
	logic                  relax_hit;
	logic                  sel_hit;

	// Handshake and counter decode
	assign in_acc      = in_valid && !in_stall;
	assign in_stall    = (state_q != ST_IDLE);
	assign cnt_idx     = cnt_q[NW-1:0];
	assign issue       = (cnt_q < CW'(NODE_COUNT));
	assign scan_state  = (state_q == ST_INIT) || (state_q == ST_SEL) || (state_q == ST_RELAX);
	assign scan_done   = !issue && !v_s1;
	assign out_free    = !out_valid_q || !out_stall;
	assign last_k      = (cnt_idx == NW'(OUT_N - 1));
	assign wr_in_range = (32'(in_word.from_node) < 32'(NODE_COUNT)) &&
	                     (32'(in_word.to_node) < 32'(NODE_COUNT));

	// Weight matrix: written by load words, read by row during init and relax
	assign w_we    = in_acc && (in_word.op == spme_pkg::OP_LOAD) && wr_in_range;
	assign w_waddr = (AW'(in_word.from_node) * AW'(NODE_COUNT)) + AW'(in_word.to_node);

	always_comb begin
		unique case (state_q)
			ST_INIT:  w_raddr = AW'(cnt_idx);
			ST_RELAX: w_raddr = (AW'(pick_q) * AW'(NODE_COUNT)) + AW'(cnt_idx);
			default:  w_raddr = '0;
		endcase
	end

	spme_ram #(
		.WIDTH (WW),
		.DEPTH (NODE_COUNT * NODE_COUNT)
	) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (in_word.edge_weight),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	// Relaxation: saturating candidate distance through the chosen node
	assign d_dist    = d_rdata[DW-1 -: DSW];
	assign d_pred    = d_rdata[NW-1:0];
	assign sum       = {1'b0, best_q} + (DSW + 1)'(w_rdata);
	assign cand      = sum[DSW] ? {DSW{1'b1}} : sum[DSW-1:0];
	assign relax_hit = v_s1 && !visited_q[idx_s1] && (cand < d_dist);
	assign sel_hit   = v_s1 && !visited_q[idx_s1] && (d_dist < best_q);

	// Distance and predecessor memory: row 0 copy at init, updates on relax
	always_comb begin
		unique case (state_q)
			ST_INIT: begin
				d_we    = v_s1;
				d_wdata = {DSW'(w_rdata), NW'(0)};
			end
			ST_RELAX: begin
				d_we    = relax_hit;
				d_wdata = {cand, pick_q};
			end
			default: begin
				d_we    = 1'b0;
				d_wdata = {cand, pick_q};
			end
		endcase
	end

	spme_ram #(
		.WIDTH (DW),
		.DEPTH (NODE_COUNT)
	) u_dist_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (idx_s1),
		.wdata (d_wdata),
		.raddr (cnt_idx),
		.rdata (d_rdata)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_edge_q <= spme_pkg::NO_EDGE_RESET;
		end else if (cfg_wr_en) begin
			no_edge_q <= cfg_wr_data;
		end
	end

	// Read pipeline tag: which entry's data arrives next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= scan_state && issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_idx;
	end

	// Nearest-node search state
	always_ff @(posedge clk) begin
		if ((state_q == ST_SEL) && sel_hit) begin
			best_q <= d_dist;
			pick_q <= idx_s1;
		end else if (scan_done && ((state_q == ST_INIT) || (state_q == ST_RELAX))) begin
			best_q <= DSW'(no_edge_q);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			visited_q <= '0;
			found_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (in_word.op == spme_pkg::OP_RUN)) begin
						visited_q <= NODE_COUNT'(1);
						cnt_q     <= '0;
						state_q   <= ST_INIT;
					end
				end
				ST_INIT: begin
					if (issue) begin
						cnt_q <= cnt_q + CW'(1);
					end else if (scan_done) begin
						cnt_q   <= '0;
						found_q <= 1'b0;
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					if (issue) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (sel_hit) begin
						found_q <= 1'b1;
					end
					if (scan_done) begin
						if (found_q) begin
							visited_q[pick_q] <= 1'b1;
							cnt_q             <= CW'(1);
							state_q           <= ST_RELAX;
						end else begin
							cnt_q   <= '0;
							state_q <= ST_OUT_RD;
						end
					end
				end
				ST_RELAX: begin
					if (issue) begin
						cnt_q <= cnt_q + CW'(1);
					end else if (scan_done) begin
						cnt_q   <= '0;
						found_q <= 1'b0;
						state_q <= ST_SEL;
					end
				end
				ST_OUT_RD: begin
					if (out_free) begin
						state_q <= ST_OUT_LD;
					end
				end
				ST_OUT_LD: begin
					if (last_k) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= ST_OUT_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: holds one result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT_LD) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT_LD) begin
			out_word_q.node_index    <= spme_pkg::ID_WIDTH'(cnt_idx);
			out_word_q.path_distance <= d_dist;
			out_word_q.predecessor   <= spme_pkg::ID_WIDTH'(d_pred);
			out_word_q.last_result   <= last_k;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// Checks
	a_out_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT_LD))
		else $error("result word appeared outside the load step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT_LD) |-> !out_valid_q)
		else $error("result word overwritten before it was taken");

	a_source_kept: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RELAX) && d_we) |-> (idx_s1 != NW'(0)))
		else $error("relaxation wrote the source node");

	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (in_word.op == spme_pkg::OP_RUN)) |=>
		((visited_q == NODE_COUNT'(1)) && (state_q == ST_INIT)))
		else $error("run did not start from a clean visited set");

endmodule
